// ===== rtl/edf_pkg.sv =====
// Shared types, codes and constants of the EDF transmit scheduler.
package edf_pkg;

  localparam int DEF_QUEUE_DEPTH = 128;
  localparam int DEF_TIME_WIDTH  = 32;

  localparam logic [10:0] MIN_PAYLOAD = 11'd46;
  localparam logic [10:0] MAX_PAYLOAD = 11'd1500;
  localparam logic [14:0] GAP_BITS    = 15'd96;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_CLASS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BIT = 3'd4;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TX   = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [10:0] length_bytes;
    logic [31:0] deadline_or_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        tx_start;
    logic [31:0] tx_deadline;
    logic [10:0] tx_length_bytes;
    logic [1:0]  tx_phase;
    logic [31:0] accepted_count;
    logic [31:0] dropped_count;
    logic [31:0] video_dropped_count;
    logic [31:0] deadline_miss_count;
  } out_item_t;

endpackage

// ===== rtl/edf_tx_queue_scheduler_top.sv =====
// Top level of the EDF transmit scheduler: queue in RAM, sequential scan for the minimum.
//
//  channel | ports                          | transfer
//  --------+--------------------------------+----------------------------------
//  input   | start, busy, in_data           | start high while busy low
//  result  | out_valid, out_data            | out_valid high, one cycle, no stall
//  config  | cfg_we, cfg_index, cfg_wdata   | cfg_we high
//
// An item with no frame start goes through S_EXEC and then S_OUT, where its result
// is strobed; the next transfer is taken once the block is back in S_IDLE.
// An item that starts a frame scans the queue RAM one entry a cycle through
// its single read port in S_SCAN, then passes S_MOVE and S_WR before the strobe
// in S_OUT; the scan covers all the entries stored.
// Synchronous active-low reset clears control state; the RAM needs no clear.
// Only one item is in work at a time; the result is never held off.
module edf_tx_queue_scheduler_top
  import edf_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = TIME_WIDTH;
  localparam int MW = TW + 11 + 32;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SCAN = 6'b000100,
    S_MOVE = 6'b001000,
    S_WR   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [6:0] queue_limit_r;
  logic       switch_mode_r, video_class_r;
  logic [6:0] header_bytes_r;
  logic [7:0] ticks_per_bit_r;

  // item and state
  in_item_t   item_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [TW-1:0] now_r, now_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [14:0] bits_r, bits_nxt;
  logic [7:0]  pre_r, pre_nxt;
  logic [31:0] cnt_acc_r, cnt_acc_nxt, cnt_drop_r, cnt_drop_nxt;
  logic [31:0] cnt_vid_r, cnt_vid_nxt, cnt_miss_r, cnt_miss_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        started_r, started_nxt;

  // scan
  logic [CW-1:0] k_r, k_nxt;
  logic [TW-1:0] best_dl_r, best_dl_nxt;
  logic [10:0]   best_len_r, best_len_nxt;
  logic [31:0]   best_ord_r, best_ord_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata;
  logic [TW-1:0] rd_dl;
  logic [10:0]   rd_len;
  logic [31:0]   rd_ord;

  edf_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_dl  = rdata[MW-1 -: TW];
  assign rd_len = rdata[42:32];
  assign rd_ord = rdata[31:0];

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // frame built from the latched item
  logic [10:0]   padded;
  logic [TW-1:0] arg_tw, fdl;
  logic [10:0]   flen;
  logic          oversize, full;
  logic [7:0]    tpb;
  logic [7:0]    pre_inc;
  logic [14:0]   bits_dec;
  logic [1:0]    ph_tick;
  logic [CW-1:0] last;
  logic          better;

  always_comb begin
    padded   = (item_r.length_bytes < MIN_PAYLOAD) ? MIN_PAYLOAD : item_r.length_bytes;
    arg_tw   = TW'(item_r.deadline_or_priority);
    fdl      = switch_mode_r ? arg_tw : now_r + arg_tw - TW'(1);
    flen     = switch_mode_r ? item_r.length_bytes : padded + 11'(header_bytes_r);
    oversize = !switch_mode_r && (padded > MAX_PAYLOAD);
    full     = (32'(count_r) > 32'(queue_limit_r)) || (32'(count_r) >= 32'(QUEUE_DEPTH));
    tpb      = (ticks_per_bit_r == 8'd0) ? 8'd1 : ticks_per_bit_r;
    last     = count_r - CW'(1);
    better   = (rd_dl < best_dl_r) ||
               ((rd_dl == best_dl_r) && (rd_ord - best_ord_r) >= 32'h8000_0000);
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    seq_nxt      = seq_r;
    now_nxt      = now_r;
    phase_nxt    = phase_r;
    bits_nxt     = bits_r;
    pre_nxt      = pre_r;
    cnt_acc_nxt  = cnt_acc_r;
    cnt_drop_nxt = cnt_drop_r;
    cnt_vid_nxt  = cnt_vid_r;
    cnt_miss_nxt = cnt_miss_r;
    status_nxt   = status_r;
    started_nxt  = started_r;
    k_nxt        = k_r;
    best_dl_nxt  = best_dl_r;
    best_len_nxt = best_len_r;
    best_ord_nxt = best_ord_r;
    best_idx_nxt = best_idx_r;
    we           = 1'b0;
    waddr        = count_r[AW-1:0];
    wdata        = {fdl, flen, seq_r};
    raddr        = k_r[AW-1:0];
    pre_inc      = pre_r;
    bits_dec     = bits_r;
    ph_tick      = phase_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt  = ST_OK;
        started_nxt = 1'b0;
        k_nxt       = '0;
        state_nxt   = S_OUT;
        if (item_r.opcode == OP_TICK) begin
          now_nxt = now_r + TW'(1);
          if (phase_r != PH_IDLE) begin
            if (bits_r != 15'd0) begin
              pre_inc = pre_r + 8'd1;
              if (pre_inc >= tpb) begin
                pre_inc  = 8'd0;
                bits_dec = bits_r - 15'd1;
              end
            end
            pre_nxt  = pre_inc;
            bits_nxt = bits_dec;
            if (bits_dec == 15'd0) begin
              if (phase_r == PH_TX) begin
                ph_tick  = PH_GAP;
                bits_nxt = GAP_BITS;
                pre_nxt  = 8'd0;
              end else begin
                ph_tick = PH_IDLE;
              end
            end
          end
          phase_nxt = ph_tick;
          if (ph_tick == PH_IDLE && count_r != '0) begin
            state_nxt = S_SCAN;
          end
        end else if (oversize || full) begin
          status_nxt   = oversize ? ST_OVERSIZE : ST_FULL;
          cnt_drop_nxt = sat_inc(cnt_drop_r);
          if (video_class_r) begin
            cnt_vid_nxt = sat_inc(cnt_vid_r);
          end
        end else begin
          we          = 1'b1;
          seq_nxt     = seq_r + 32'd1;
          count_nxt   = count_r + CW'(1);
          cnt_acc_nxt = sat_inc(cnt_acc_r);
          if (fdl < now_r) begin
            cnt_miss_nxt = sat_inc(cnt_miss_r);
          end
          if (phase_r == PH_IDLE) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read entry k, compare entry k-1 whose data arrives now
        k_nxt = k_r + CW'(1);
        if (k_r != '0) begin
          if (k_r == CW'(1) || better) begin
            best_dl_nxt  = rd_dl;
            best_len_nxt = rd_len;
            best_ord_nxt = rd_ord;
            best_idx_nxt = AW'(k_r - CW'(1));
          end
        end
        if (k_r == count_r) begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        raddr     = last[AW-1:0];
        state_nxt = S_WR;
      end
      S_WR: begin
        // last entry fills the hole left by the chosen one
        we          = (best_idx_r != last[AW-1:0]);
        waddr       = best_idx_r;
        wdata       = rdata;
        count_nxt   = last;
        started_nxt = 1'b1;
        phase_nxt   = PH_TX;
        bits_nxt    = {1'b0, best_len_r, 3'b000};
        pre_nxt     = 8'd0;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      queue_limit_r   <= 7'd127;
      switch_mode_r   <= 1'b0;
      video_class_r   <= 1'b0;
      header_bytes_r  <= 7'd18;
      ticks_per_bit_r <= 8'd1;
      count_r         <= '0;
      seq_r           <= '0;
      now_r           <= '0;
      phase_r         <= PH_IDLE;
      bits_r          <= '0;
      pre_r           <= '0;
      cnt_acc_r       <= '0;
      cnt_drop_r      <= '0;
      cnt_vid_r       <= '0;
      cnt_miss_r      <= '0;
      status_r        <= ST_OK;
      started_r       <= 1'b0;
      k_r             <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      seq_r      <= seq_nxt;
      now_r      <= now_nxt;
      phase_r    <= phase_nxt;
      bits_r     <= bits_nxt;
      pre_r      <= pre_nxt;
      cnt_acc_r  <= cnt_acc_nxt;
      cnt_drop_r <= cnt_drop_nxt;
      cnt_vid_r  <= cnt_vid_nxt;
      cnt_miss_r <= cnt_miss_nxt;
      status_r   <= status_nxt;
      started_r  <= started_nxt;
      k_r        <= k_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_QUEUE_LIMIT:   queue_limit_r   <= cfg_wdata[6:0];
          CFG_SWITCH_MODE:   switch_mode_r   <= cfg_wdata[0];
          CFG_VIDEO_CLASS:   video_class_r   <= cfg_wdata[0];
          CFG_HEADER_BYTES:  header_bytes_r  <= cfg_wdata[6:0];
          CFG_TICKS_PER_BIT: ticks_per_bit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      item_r <= in_data;
    end
    best_dl_r  <= best_dl_nxt;
    best_len_r <= best_len_nxt;
    best_ord_r <= best_ord_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    out_data.status              = status_r;
    out_data.tx_start            = started_r;
    out_data.tx_deadline         = started_r ? 32'(best_dl_r) : 32'd0;
    out_data.tx_length_bytes     = started_r ? best_len_r : 11'd0;
    out_data.tx_phase            = phase_r;
    out_data.accepted_count      = cnt_acc_r;
    out_data.dropped_count       = cnt_drop_r;
    out_data.video_dropped_count = cnt_vid_r;
    out_data.deadline_miss_count = cnt_miss_r;
  end

endmodule

// ===== rtl/edf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module edf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/edf_tx_queue_scheduler_top_test.sv =====
// Self-checking testbench for the EDF transmit scheduler: random and directed items.
module edf_tx_queue_scheduler_top_test;
  import edf_pkg::*;

  localparam int  DEPTH       = 128;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_WAIT  = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  edf_tx_queue_scheduler_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // scheduler shadow state
  bit [31:0] q_deadline [DEPTH];
  bit [10:0] q_length [DEPTH];
  bit [31:0] q_order [DEPTH];
  int unsigned q_count;
  bit [31:0] seq_num, now_t;
  logic [1:0] line_phase;
  int unsigned bits_left, prescale;
  bit [31:0] cnt_accept, cnt_drop, cnt_video, cnt_miss;
  bit [6:0] r_limit = 7'd127;
  bit       r_switch = 1'b0;
  bit       r_video = 1'b0;
  bit [6:0] r_header = 7'd18;
  bit [7:0] r_tpb = 8'd1;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit xfer_seen = 1'b0;
  int burst_left = 0, gap_left = 0;

  function automatic bit [31:0] sat_inc(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic pop_earliest(inout out_item_t r);
    int best;
    best = 0;
    if (line_phase != PH_IDLE || q_count == 0) return;
    for (int i = 1; i < q_count; i++)
      if (q_deadline[i] < q_deadline[best] ||
          (q_deadline[i] == q_deadline[best] && (q_order[i] - q_order[best]) >= 32'h8000_0000))
        best = i;
    r.tx_start = 1'b1;
    r.tx_deadline = q_deadline[best];
    r.tx_length_bytes = q_length[best];
    q_count--;
    q_deadline[best] = q_deadline[q_count];
    q_length[best] = q_length[q_count];
    q_order[best] = q_order[q_count];
    line_phase = PH_TX;
    bits_left = r.tx_length_bytes * 8;
    prescale = 0;
  endtask

  task automatic schedule_item(input in_item_t it, output out_item_t r);
    bit [31:0] fdl;
    bit [10:0] bytes, flen;
    int unsigned tpb;
    r = '0;
    r.status = ST_OK;
    if (it.opcode == OP_TICK) begin
      now_t = now_t + 32'd1;
      if (line_phase != PH_IDLE) begin
        if (bits_left > 0) begin
          tpb = (r_tpb == 0) ? 1 : r_tpb;
          prescale++;
          if (prescale >= tpb) begin
            prescale = 0;
            bits_left--;
          end
        end
        if (bits_left == 0) begin
          if (line_phase == PH_TX) begin
            line_phase = PH_GAP;
            bits_left = GAP_BITS;
            prescale = 0;
          end else line_phase = PH_IDLE;
        end
      end
      pop_earliest(r);
    end else begin
      bytes = it.length_bytes;
      if (r_switch) begin
        fdl = it.deadline_or_priority;
        flen = bytes;
      end else begin
        fdl = now_t + it.deadline_or_priority - 32'd1;
        if (bytes < MIN_PAYLOAD) bytes = MIN_PAYLOAD;
        flen = bytes + r_header;
      end
      if (!r_switch && bytes > MAX_PAYLOAD) r.status = ST_OVERSIZE;
      else if (q_count > r_limit || q_count >= DEPTH) r.status = ST_FULL;
      else begin
        q_deadline[q_count] = fdl;
        q_length[q_count] = flen;
        q_order[q_count] = seq_num;
        seq_num++;
        q_count++;
        cnt_accept = sat_inc(cnt_accept);
        if (fdl < now_t) cnt_miss = sat_inc(cnt_miss);
        pop_earliest(r);
      end
      if (r.status != ST_OK) begin
        cnt_drop = sat_inc(cnt_drop);
        if (r_video) cnt_video = sat_inc(cnt_video);
      end
    end
    r.tx_phase = line_phase;
    r.accepted_count = cnt_accept;
    r.dropped_count = cnt_drop;
    r.video_dropped_count = cnt_video;
    r.deadline_miss_count = cnt_miss;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch @%0d %s: got %0h, expected %0h", cycles, field, got, want);
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // result check and input transfer capture
  always @(posedge clk) begin
    out_item_t want, pred;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("status: fail");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          want = expected_results.pop_front();
          compare_field("status", out_data.status, want.status);
          compare_field("tx_start", out_data.tx_start, want.tx_start);
          compare_field("tx_deadline", out_data.tx_deadline, want.tx_deadline);
          compare_field("tx_length_bytes", out_data.tx_length_bytes, want.tx_length_bytes);
          compare_field("tx_phase", out_data.tx_phase, want.tx_phase);
          compare_field("accepted_count", out_data.accepted_count, want.accepted_count);
          compare_field("dropped_count", out_data.dropped_count, want.dropped_count);
          compare_field("video_dropped_count", out_data.video_dropped_count,
                        want.video_dropped_count);
          compare_field("deadline_miss_count", out_data.deadline_miss_count,
                        want.deadline_miss_count);
        end
      end
      if (start && !busy) begin
        schedule_item(in_data, pred);
        expected_results.push_back(pred);
        xfer_seen = 1'b1;
      end
    end
  end

  // item driver: bursts with random gaps
  always @(negedge clk) begin
    logic     nxt_start;
    in_item_t nxt_data;
    nxt_start = start;
    nxt_data = in_data;
    if (!start || xfer_seen) begin
      xfer_seen = 1'b0;
      nxt_start = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (rst_n && pending_items.size() > 0) begin
        nxt_data = pending_items.pop_front();
        nxt_start = 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5);
        end
      end
    end
    start <= nxt_start;
    in_data <= nxt_data;
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_results.size() > 0 || busy)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_QUEUE_LIMIT:   r_limit = val[6:0];
      CFG_SWITCH_MODE:   r_switch = val[0];
      CFG_VIDEO_CLASS:   r_video = val[0];
      CFG_HEADER_BYTES:  r_header = val[6:0];
      CFG_TICKS_PER_BIT: r_tpb = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_item(input logic op, input logic [10:0] len, input logic [31:0] arg);
    in_item_t it;
    it.opcode = op;
    it.length_bytes = len;
    it.deadline_or_priority = arg;
    pending_items.push_back(it);
  endtask

  task automatic add_random_item();
    logic [10:0] len;
    logic [31:0] arg;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) add_item(OP_TICK, 11'($urandom), $urandom);
    else begin
      if (r_switch) begin
        len = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 12));
        arg = ($urandom_range(0, 3) == 0) ? $urandom : now_t + $urandom_range(0, 200);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 60));
        arg = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 300);
      end
      add_item(OP_ENQUEUE, len, arg);
    end
  endtask

  initial begin
    logic [7:0] plan [5][5];
    plan[0] = '{8'd127, 8'd1, 8'd0, 8'd0,   8'd1};
    plan[1] = '{8'd3,   8'd0, 8'd1, 8'd64,  8'd1};
    plan[2] = '{8'd0,   8'd1, 8'd1, 8'd127, 8'd2};
    plan[3] = '{8'd10,  8'd0, 8'd0, 8'd18,  8'd0};
    plan[4] = '{8'd127, 8'd1, 8'd0, 8'd5,   8'd255};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // node mode, reset register values: padding, oversize, deadline wrap
    add_item(OP_ENQUEUE, 11'd0, 32'd0);
    add_item(OP_ENQUEUE, 11'd45, 32'hFFFF_FFFF);
    add_item(OP_ENQUEUE, 11'd46, 32'd5);
    add_item(OP_ENQUEUE, 11'd1500, 32'd5);
    add_item(OP_ENQUEUE, 11'd1501, 32'd1);
    add_item(OP_ENQUEUE, 11'd2047, 32'd1);
    repeat (4) add_item(OP_TICK, 11'h7FF, 32'hFFFF_FFFF);
    wait_drained();

    // switch mode with queue limit zero: tail drop while line busy, video loss
    write_reg(CFG_SWITCH_MODE, 8'd1);
    write_reg(CFG_VIDEO_CLASS, 8'd1);
    write_reg(CFG_QUEUE_LIMIT, 8'd0);
    write_reg(CFG_TICKS_PER_BIT, 8'd255);
    write_reg(CFG_HEADER_BYTES, 8'd0);
    add_item(OP_ENQUEUE, 11'd0, 32'd0);
    add_item(OP_ENQUEUE, 11'd2047, 32'hFFFF_FFFF);
    add_item(OP_ENQUEUE, 11'd1, 32'd7);
    repeat (3) add_item(OP_TICK, 11'd0, 32'd0);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_QUEUE_LIMIT, plan[p][0]);
      write_reg(CFG_SWITCH_MODE, plan[p][1]);
      write_reg(CFG_VIDEO_CLASS, plan[p][2]);
      write_reg(CFG_HEADER_BYTES, plan[p][3]);
      write_reg(CFG_TICKS_PER_BIT, plan[p][4]);
      repeat (90) add_random_item();
      wait_drained();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/edf_pkg.sv
rtl/edf_ram.sv
rtl/edf_tx_queue_scheduler_top.sv
tb/edf_tx_queue_scheduler_top_test.sv
